// ===== design/osr_pkg.sv =====
// Shared types and constants for the overwriting sample ring.
package osr_pkg;

	localparam int DEPTH_DEF   = 512;
	localparam int MAX_OUT_DEF = 64;
	localparam int CNT_W       = 7;
	localparam int IDX_W       = 6;
	localparam int OCC_OUT_W   = 10;

	localparam logic [CNT_W-1:0] RECENT_CAP = 7'd64;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_QUERY  = 2'd1,
		REQ_RECENT = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] ts;
		logic [7:0]  addr;
		logic [31:0] val;
	} sample_t;

	typedef struct packed {
		sample_t              smp;
		logic                 has;
		logic [IDX_W-1:0]     idx;
		logic                 last;
		logic [OCC_OUT_W-1:0] occ;
	} rsp_t;

endpackage

// ===== design/osr_store.sv =====
// Sample memory with one write port and one registered read port.
module osr_store #(
	parameter int DEPTH = osr_pkg::DEPTH_DEF,
	localparam int PTR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [PTR_W-1:0]  waddr,
	input  osr_pkg::sample_t  wdata,
	input  logic              re,
	input  logic [PTR_W-1:0]  raddr,
	output osr_pkg::sample_t  rdata
);

	osr_pkg::sample_t mem_q [DEPTH];
	osr_pkg::sample_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/osr_ctrl.sv =====
// Request sequencer: ring pointers, scan through the memory and the result register.
module osr_ctrl #(
	parameter int DEPTH   = osr_pkg::DEPTH_DEF,
	parameter int MAX_OUT = osr_pkg::MAX_OUT_DEF,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int OCC_W = $clog2(DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [1:0]                        req_type,
	input  logic [31:0]                       sample_timestamp,
	input  logic [7:0]                        sample_reg_addr,
	input  logic [31:0]                       sample_value_bits,
	input  logic [31:0]                       range_start,
	input  logic [31:0]                       range_end,
	input  logic [osr_pkg::CNT_W-1:0]         recent_count,
	input  logic [osr_pkg::CNT_W-1:0]         result_limit,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output osr_pkg::rsp_t                     rsp,
	output logic                              mem_we,
	output logic [PTR_W-1:0]                  mem_waddr,
	output osr_pkg::sample_t                  mem_wdata,
	output logic                              mem_re,
	output logic [PTR_W-1:0]                  mem_raddr,
	input  osr_pkg::sample_t                  mem_rdata
);

	localparam int CW = osr_pkg::CNT_W;
	localparam int WW = (OCC_W > CW) ? OCC_W : CW;
	localparam int SW = PTR_W + 8;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	osr_pkg::state_t state_q, state_d;
	osr_pkg::req_t   req_kind;

	logic [PTR_W-1:0] wp_q, op_q, rd_ptr_q;
	logic [OCC_W-1:0] occ_q, rem_q, occ_new;
	logic [CW-1:0]    n_q, lim_q, n_next, lim_in, want, rcnt;
	logic [WW-1:0]    occ_w, want_w, min_w;
	logic [SW-1:0]    wp_s, rcnt_s, start_s;
	logic [31:0]      lo_q, hi_q;
	logic             recent_q, s1_valid_q, held_v_q, rsp_valid_q;
	osr_pkg::sample_t held_q;
	logic [osr_pkg::IDX_W-1:0] held_idx_q;
	osr_pkg::rsp_t    rsp_q;

	logic can_push, accept, is_ack, full, in_range, s1_match, s1_take;
	logic issue, hit, scan_done, push_mid, push_fin;

	assign req_kind = osr_pkg::req_t'(req_type);
	assign full     = (occ_q == OCC_W'(DEPTH));
	assign occ_new  = full ? occ_q : occ_q + 1'b1;

	assign lim_in = (result_limit > CW'(MAX_OUT)) ? CW'(MAX_OUT) : result_limit;
	assign want   = (recent_count > osr_pkg::RECENT_CAP) ? osr_pkg::RECENT_CAP : recent_count;
	assign occ_w  = WW'(occ_q);
	assign want_w = WW'(want);
	assign min_w  = (occ_w < want_w) ? occ_w : want_w;
	assign rcnt   = (min_w < WW'(lim_in)) ? CW'(min_w) : lim_in;
	assign wp_s   = SW'(wp_q);
	assign rcnt_s = SW'(rcnt);
	assign start_s = (wp_s >= rcnt_s) ? wp_s - rcnt_s : wp_s + SW'(DEPTH) - rcnt_s;

	assign in_range = (mem_rdata.ts >= lo_q) && (mem_rdata.ts <= hi_q);

	always_comb begin
		can_push  = !rsp_valid_q || rsp_ready;
		req_ready = (state_q == osr_pkg::ST_IDLE) && can_push;
		accept    = req_valid && req_ready;
		is_ack    = (req_kind == osr_pkg::REQ_APPEND) || (req_kind == osr_pkg::REQ_CLEAR);
		s1_match  = s1_valid_q && (n_q < lim_q) && (recent_q || in_range);
		s1_take   = !s1_match || !held_v_q || can_push;
		issue     = (state_q == osr_pkg::ST_SCAN) && (rem_q != '0) && s1_take;
		hit       = (state_q == osr_pkg::ST_SCAN) && s1_match && s1_take;
		n_next    = n_q + CW'(hit);
		scan_done = (state_q == osr_pkg::ST_SCAN) &&
			((n_next == lim_q) || ((rem_q == '0) && s1_take));
		push_mid  = hit && held_v_q;
		push_fin  = (state_q == osr_pkg::ST_DONE) && can_push;
		mem_we    = accept && (req_kind == osr_pkg::REQ_APPEND);
		mem_waddr = wp_q;
		mem_wdata = '{ts: sample_timestamp, addr: sample_reg_addr, val: sample_value_bits};
		mem_re    = issue;
		mem_raddr = rd_ptr_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			osr_pkg::ST_IDLE: begin
				if (accept && !is_ack) begin
					state_d = osr_pkg::ST_SCAN;
				end
			end
			osr_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = osr_pkg::ST_DONE;
				end
			end
			osr_pkg::ST_DONE: begin
				if (can_push) begin
					state_d = osr_pkg::ST_IDLE;
				end
			end
			default: state_d = osr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= osr_pkg::ST_IDLE;
			wp_q        <= '0;
			op_q        <= '0;
			occ_q       <= '0;
			rd_ptr_q    <= '0;
			rem_q       <= '0;
			n_q         <= '0;
			lim_q       <= '0;
			recent_q    <= 1'b0;
			s1_valid_q  <= 1'b0;
			held_v_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				case (req_kind)
					osr_pkg::REQ_APPEND: begin
						wp_q  <= ptr_inc(wp_q);
						occ_q <= occ_new;
						if (full) begin
							op_q <= ptr_inc(op_q);
						end
					end
					osr_pkg::REQ_CLEAR: begin
						wp_q  <= '0;
						op_q  <= '0;
						occ_q <= '0;
					end
					osr_pkg::REQ_RECENT: begin
						recent_q <= 1'b1;
						rd_ptr_q <= PTR_W'(start_s);
						rem_q    <= OCC_W'(rcnt);
						lim_q    <= rcnt;
						n_q      <= '0;
						held_v_q <= 1'b0;
					end
					osr_pkg::REQ_QUERY: begin
						recent_q <= 1'b0;
						rd_ptr_q <= op_q;
						rem_q    <= occ_q;
						lim_q    <= lim_in;
						n_q      <= '0;
						held_v_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (issue) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
				rem_q    <= rem_q - 1'b1;
			end
			if (state_q == osr_pkg::ST_SCAN) begin
				n_q        <= n_next;
				s1_valid_q <= !scan_done && (issue || (s1_valid_q && !s1_take));
			end
			if (hit) begin
				held_v_q <= 1'b1;
			end else if (push_fin) begin
				held_v_q <= 1'b0;
			end
			if ((accept && is_ack) || push_mid || push_fin) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_ack) begin
			lo_q <= range_start;
			hi_q <= range_end;
		end
		if (hit) begin
			held_q     <= mem_rdata;
			held_idx_q <= n_q[osr_pkg::IDX_W-1:0];
		end
		if (accept && is_ack) begin
			rsp_q.smp  <= '0;
			rsp_q.has  <= 1'b0;
			rsp_q.idx  <= '0;
			rsp_q.last <= 1'b1;
			rsp_q.occ  <= (req_kind == osr_pkg::REQ_APPEND) ?
				osr_pkg::OCC_OUT_W'(occ_new) : '0;
		end else if (push_mid || push_fin) begin
			rsp_q.smp  <= held_v_q ? held_q : '0;
			rsp_q.has  <= held_v_q;
			rsp_q.idx  <= held_v_q ? held_idx_q : '0;
			rsp_q.last <= push_fin;
			rsp_q.occ  <= osr_pkg::OCC_OUT_W'(occ_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_held_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		held_v_q |-> (state_q != osr_pkg::ST_IDLE))
		else $error("Held sample present while idle.");

	a_count_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != osr_pkg::ST_IDLE) |-> (n_q <= lim_q))
		else $error("Emitted count exceeds the limit.");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> (state_q == osr_pkg::ST_SCAN))
		else $error("Read data pending outside a scan.");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(DEPTH))
		else $error("Occupancy above ring depth.");

	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_ack) |=> (rsp_valid_q && rsp_q.last && !rsp_q.has))
		else $error("Append or clear did not produce a final empty result.");

endmodule

// ===== design/overwriting_sample_ring_with_time_query_top.sv =====
// Top level of the overwriting sample ring with time-range and most-recent queries.
//
//   Channel  Handshake             Payload
//   request  req_valid/req_ready   req_type, sample_*, range_*, recent_count, result_limit
//   result   rsp_valid/rsp_ready   out_*, has_sample, result_index, last, occupancy
//
// An append or clear gives its single result in the cycle after it is taken.
// A query scans the stored samples through the single memory read port, one entry per
// cycle while a stalled result does not hold it; a read-recent scans only the newest
// samples, up to the requested count. A request is taken only between answers.
// Reset empties the ring at once; memory contents are left as they are.
// A stalled result holds the scan while a further sample is waiting for the output.
module overwriting_sample_ring_with_time_query_top #(
	parameter int DEPTH   = osr_pkg::DEPTH_DEF,
	parameter int MAX_OUT = osr_pkg::MAX_OUT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [1:0]                    req_type,
	input  logic [31:0]                   sample_timestamp,
	input  logic [7:0]                    sample_reg_addr,
	input  logic [31:0]                   sample_value_bits,
	input  logic [31:0]                   range_start,
	input  logic [31:0]                   range_end,
	input  logic [osr_pkg::CNT_W-1:0]     recent_count,
	input  logic [osr_pkg::CNT_W-1:0]     result_limit,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [31:0]                   out_timestamp,
	output logic [7:0]                    out_reg_addr,
	output logic [31:0]                   out_value_bits,
	output logic                          has_sample,
	output logic [osr_pkg::IDX_W-1:0]     result_index,
	output logic                          last,
	output logic [osr_pkg::OCC_OUT_W-1:0] occupancy
);

	localparam int PTR_W = $clog2(DEPTH);

	logic             mem_we, mem_re;
	logic [PTR_W-1:0] mem_waddr, mem_raddr;
	osr_pkg::sample_t mem_wdata, mem_rdata;
	osr_pkg::rsp_t    rsp;

	osr_ctrl #(
		.DEPTH   (DEPTH),
		.MAX_OUT (MAX_OUT)
	) u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.req_valid         (req_valid),
		.req_ready         (req_ready),
		.req_type          (req_type),
		.sample_timestamp  (sample_timestamp),
		.sample_reg_addr   (sample_reg_addr),
		.sample_value_bits (sample_value_bits),
		.range_start       (range_start),
		.range_end         (range_end),
		.recent_count      (recent_count),
		.result_limit      (result_limit),
		.rsp_valid         (rsp_valid),
		.rsp_ready         (rsp_ready),
		.rsp               (rsp),
		.mem_we            (mem_we),
		.mem_waddr         (mem_waddr),
		.mem_wdata         (mem_wdata),
		.mem_re            (mem_re),
		.mem_raddr         (mem_raddr),
		.mem_rdata         (mem_rdata)
	);

	osr_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign out_timestamp  = rsp.smp.ts;
	assign out_reg_addr   = rsp.smp.addr;
	assign out_value_bits = rsp.smp.val;
	assign has_sample     = rsp.has;
	assign result_index   = rsp.idx;
	assign last           = rsp.last;
	assign occupancy      = rsp.occ;

endmodule
